### rtl/sts_pkg.sv
package sts_pkg;

  // Source size limit and derived widths
  localparam int unsigned MaxSource    = 65536;
  localparam int unsigned PosW         = $clog2(MaxSource + 1);
  localparam int unsigned FieldW       = 16;
  localparam int unsigned LineW        = 16;
  localparam int unsigned KindW        = 6;
  localparam int unsigned ByteW        = 8;

  // Keyword matching
  localparam int unsigned KeywordChars = 6;
  localparam int unsigned PrefixW      = 8 * KeywordChars;
  localparam int unsigned WordLenW     = $clog2(KeywordChars + 2);
  localparam int unsigned KwCount      = 14;

  // Result queue
  localparam int unsigned ResultDepth  = 4;
  localparam int unsigned ResultPtrW   = $clog2(ResultDepth);
  localparam int unsigned ResultCntW   = $clog2(ResultDepth + 1);

  typedef logic [KindW-1:0] kind_t;

  // Token kinds
  localparam kind_t KindEnd          = 6'd0;
  localparam kind_t KindNumber       = 6'd1;
  localparam kind_t KindString       = 6'd2;
  localparam kind_t KindIdent        = 6'd3;
  localparam kind_t KindUnknown      = 6'd4;
  localparam kind_t KindLParen       = 6'd5;
  localparam kind_t KindRParen       = 6'd6;
  localparam kind_t KindLBracket     = 6'd7;
  localparam kind_t KindRBracket     = 6'd8;
  localparam kind_t KindLBrace       = 6'd9;
  localparam kind_t KindRBrace       = 6'd10;
  localparam kind_t KindComma        = 6'd11;
  localparam kind_t KindDot          = 6'd12;
  localparam kind_t KindColon        = 6'd13;
  localparam kind_t KindSemicolon    = 6'd14;
  localparam kind_t KindPlus         = 6'd15;
  localparam kind_t KindMinus        = 6'd16;
  localparam kind_t KindStar         = 6'd17;
  localparam kind_t KindSlash        = 6'd18;
  localparam kind_t KindBangEqual    = 6'd19;
  localparam kind_t KindLess         = 6'd20;
  localparam kind_t KindLessEqual    = 6'd21;
  localparam kind_t KindGreater      = 6'd22;
  localparam kind_t KindGreaterEqual = 6'd23;
  localparam kind_t KindEqual        = 6'd24;
  localparam kind_t KindEqualEqual   = 6'd25;
  localparam kind_t KindKeyword0     = 6'd26;
  localparam kind_t KindBadNumber    = 6'd40;

  // Keywords, first character in the most significant used byte
  localparam logic [PrefixW-1:0] KwText [KwCount] = '{
    48'h766172,        // var
    48'h6966,          // if
    48'h656c7365,      // else
    48'h74727565,      // true
    48'h66616c7365,    // false
    48'h6e696c,        // nil
    48'h7768696c65,    // while
    48'h666e,          // fn
    48'h72657475726e,  // return
    48'h616e64,        // and
    48'h6f72,          // or
    48'h6e6f74,        // not
    48'h737472756374,  // struct
    48'h726566         // ref
  };
  localparam logic [WordLenW-1:0] KwLen [KwCount] = '{
    3'd3, 3'd2, 3'd4, 3'd4, 3'd5, 3'd3, 3'd5,
    3'd2, 3'd6, 3'd3, 3'd2, 3'd3, 3'd6, 3'd3
  };

  typedef struct packed {
    kind_t             kind;
    logic [FieldW-1:0] start;
    logic [FieldW-1:0] length;
    logic [LineW-1:0]  line;
    logic              unterm;
    logic              last;
  } result_t;

  // Up to two results from one item, already packed toward slot 0
  typedef struct packed {
    logic    vld0;
    logic    vld1;
    result_t res0;
    result_t res1;
  } push_t;

  function automatic logic is_digit(input logic [ByteW-1:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_letter(input logic [ByteW-1:0] c);
    return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z")) || (c == "_");
  endfunction

  function automatic logic [FieldW-1:0] sat_field(input logic [PosW-1:0] v);
    return (v > PosW'({FieldW{1'b1}})) ? {FieldW{1'b1}} : v[FieldW-1:0];
  endfunction

  function automatic kind_t word_kind(input logic [PrefixW-1:0]  prefix,
                                      input logic [WordLenW-1:0] len);
    kind_t kind;
    kind = KindIdent;
    for (int k = 0; k < KwCount; k++) begin
      if ((KwLen[k] == len) && (KwText[k] == prefix)) begin
        kind = KindKeyword0 + KindW'(k);
      end
    end
    return kind;
  endfunction

  function automatic result_t make_result(input kind_t            kind,
                                          input logic [PosW-1:0]  start,
                                          input logic [PosW-1:0]  len,
                                          input logic [LineW-1:0] line,
                                          input logic             unterm);
    result_t r;
    r.kind   = kind;
    r.start  = sat_field(start);
    r.length = sat_field(len);
    r.line   = line;
    r.unterm = unterm;
    r.last   = 1'b0;
    return r;
  endfunction

endpackage

### rtl/sts_scan.sv
module sts_scan (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     item_valid_i,
  input  logic                     cmd_i,
  input  logic [sts_pkg::ByteW-1:0] source_byte_i,
  output sts_pkg::push_t           push_o
);

  typedef enum logic [3:0] {
    ModeIdle,
    ModeIdent,
    ModeInt,
    ModeDot,
    ModeFrac,
    ModeString,
    ModeComment,
    ModeBang,
    ModeLess,
    ModeGreater,
    ModeEqual
  } mode_e;

  mode_e                            mode_q, mode_d;
  logic [sts_pkg::PosW-1:0]         start_q, start_d;
  logic [sts_pkg::PosW-1:0]         pos_q, pos_d;
  logic [sts_pkg::LineW-1:0]        line_q, line_d;
  logic [sts_pkg::PrefixW-1:0]      prefix_q, prefix_d;
  logic [sts_pkg::WordLenW-1:0]     wlen_q, wlen_d;

  logic [sts_pkg::LineW-1:0]        line_inc;
  logic [sts_pkg::PosW-1:0]         span;
  logic [sts_pkg::PosW-1:0]         str_start;
  logic [sts_pkg::PosW-1:0]         str_len;
  logic                             flush_vld;
  sts_pkg::result_t                 flush_res;
  logic                             a_vld, b_vld;
  sts_pkg::result_t                 a_res, b_res;
  logic                             consumed;
  logic [sts_pkg::ByteW-1:0]        c;

  assign c         = source_byte_i;
  assign line_inc  = (line_q != {sts_pkg::LineW{1'b1}}) ? line_q + 1'b1 : line_q;
  assign span      = pos_q - start_q;
  assign str_start = start_q + 1'b1;
  assign str_len   = span - 1'b1;

  // Token left pending by the current mode; a string only closes this way at end of source
  always_comb begin
    flush_vld = 1'b0;
    flush_res = sts_pkg::make_result(sts_pkg::KindIdent, start_q, span, line_q, 1'b0);
    case (mode_q)
      ModeIdent: begin
        flush_vld = 1'b1;
        flush_res.kind = sts_pkg::word_kind(prefix_q, wlen_q);
      end
      ModeInt, ModeFrac: begin
        flush_vld = 1'b1;
        flush_res.kind = sts_pkg::KindNumber;
      end
      ModeDot: begin
        flush_vld = 1'b1;
        flush_res.kind = sts_pkg::KindBadNumber;
      end
      ModeLess: begin
        flush_vld = 1'b1;
        flush_res = sts_pkg::make_result(sts_pkg::KindLess, start_q,
                                         sts_pkg::PosW'(1), line_q, 1'b0);
      end
      ModeGreater: begin
        flush_vld = 1'b1;
        flush_res = sts_pkg::make_result(sts_pkg::KindGreater, start_q,
                                         sts_pkg::PosW'(1), line_q, 1'b0);
      end
      ModeEqual: begin
        flush_vld = 1'b1;
        flush_res = sts_pkg::make_result(sts_pkg::KindEqual, start_q,
                                         sts_pkg::PosW'(1), line_q, 1'b0);
      end
      ModeString: begin
        flush_vld = cmd_i;
        flush_res = sts_pkg::make_result(sts_pkg::KindString, str_start, str_len,
                                         line_q, 1'b1);
      end
      default: flush_vld = 1'b0;
    endcase
  end

  always_comb begin
    mode_d   = mode_q;
    start_d  = start_q;
    pos_d    = pos_q;
    line_d   = line_q;
    prefix_d = prefix_q;
    wlen_d   = wlen_q;
    a_vld    = 1'b0;
    b_vld    = 1'b0;
    a_res    = flush_res;
    b_res    = sts_pkg::make_result(sts_pkg::KindUnknown, pos_q, sts_pkg::PosW'(1),
                                    line_q, 1'b0);
    consumed = 1'b0;

    if (item_valid_i) begin
      if (cmd_i) begin
        a_vld    = flush_vld;
        b_vld    = 1'b1;
        b_res    = sts_pkg::make_result(sts_pkg::KindEnd, pos_q, '0, line_q, 1'b0);
        mode_d   = ModeIdle;
        start_d  = '0;
        pos_d    = '0;
        line_d   = sts_pkg::LineW'(1);
        prefix_d = '0;
        wlen_d   = '0;
      end else if (pos_q < sts_pkg::PosW'(sts_pkg::MaxSource)) begin
        pos_d = pos_q + 1'b1;

        case (mode_q)
          ModeIdent: begin
            if (sts_pkg::is_letter(c) || sts_pkg::is_digit(c)) begin
              consumed = 1'b1;
              if (wlen_q < sts_pkg::WordLenW'(sts_pkg::KeywordChars)) begin
                prefix_d = {prefix_q[sts_pkg::PrefixW-sts_pkg::ByteW-1:0], c};
                wlen_d   = wlen_q + 1'b1;
              end else begin
                wlen_d = sts_pkg::WordLenW'(sts_pkg::KeywordChars + 1);
              end
            end
          end
          ModeInt: begin
            if (sts_pkg::is_digit(c)) begin
              consumed = 1'b1;
            end else if (c == ".") begin
              consumed = 1'b1;
              mode_d   = ModeDot;
            end
          end
          ModeDot: begin
            if (sts_pkg::is_digit(c)) begin
              consumed = 1'b1;
              mode_d   = ModeFrac;
            end
          end
          ModeFrac: begin
            consumed = sts_pkg::is_digit(c);
          end
          ModeString: begin
            consumed = 1'b1;
            if (c == "\"") begin
              a_vld  = 1'b1;
              a_res  = sts_pkg::make_result(sts_pkg::KindString, str_start, str_len,
                                            line_q, 1'b0);
              mode_d = ModeIdle;
            end else if (c == "\n") begin
              line_d = line_inc;
            end
          end
          ModeComment: begin
            consumed = 1'b1;
            if (c == "\n") begin
              line_d = line_inc;
              mode_d = ModeIdle;
            end
          end
          ModeBang, ModeLess, ModeGreater, ModeEqual: begin
            if (c == "=") begin
              consumed = 1'b1;
              a_vld    = 1'b1;
              mode_d   = ModeIdle;
              case (mode_q)
                ModeBang:    a_res.kind = sts_pkg::KindBangEqual;
                ModeLess:    a_res.kind = sts_pkg::KindLessEqual;
                ModeGreater: a_res.kind = sts_pkg::KindGreaterEqual;
                default:     a_res.kind = sts_pkg::KindEqualEqual;
              endcase
              a_res.start  = sts_pkg::sat_field(start_q);
              a_res.length = sts_pkg::FieldW'(2);
              a_res.line   = line_q;
              a_res.unterm = 1'b0;
            end
          end
          default: consumed = 1'b0;
        endcase

        // Close the pending token, then scan the byte from idle
        if (!consumed) begin
          a_vld   = flush_vld;
          mode_d  = ModeIdle;
          start_d = pos_q;
          b_vld   = 1'b1;
          case (c)
            "(":  b_res.kind = sts_pkg::KindLParen;
            ")":  b_res.kind = sts_pkg::KindRParen;
            "[":  b_res.kind = sts_pkg::KindLBracket;
            "]":  b_res.kind = sts_pkg::KindRBracket;
            "{":  b_res.kind = sts_pkg::KindLBrace;
            "}":  b_res.kind = sts_pkg::KindRBrace;
            ",":  b_res.kind = sts_pkg::KindComma;
            ".":  b_res.kind = sts_pkg::KindDot;
            ":":  b_res.kind = sts_pkg::KindColon;
            ";":  b_res.kind = sts_pkg::KindSemicolon;
            "+":  b_res.kind = sts_pkg::KindPlus;
            "-":  b_res.kind = sts_pkg::KindMinus;
            "*":  b_res.kind = sts_pkg::KindStar;
            "/":  b_res.kind = sts_pkg::KindSlash;
            " ", "\t", "\r": b_vld = 1'b0;
            "\n": begin
              b_vld  = 1'b0;
              line_d = line_inc;
            end
            "\"": begin
              b_vld  = 1'b0;
              mode_d = ModeString;
            end
            "#": begin
              b_vld  = 1'b0;
              mode_d = ModeComment;
            end
            "!": begin
              b_vld  = 1'b0;
              mode_d = ModeBang;
            end
            "<": begin
              b_vld  = 1'b0;
              mode_d = ModeLess;
            end
            ">": begin
              b_vld  = 1'b0;
              mode_d = ModeGreater;
            end
            "=": begin
              b_vld  = 1'b0;
              mode_d = ModeEqual;
            end
            default: begin
              if (sts_pkg::is_digit(c)) begin
                b_vld  = 1'b0;
                mode_d = ModeInt;
              end else if (sts_pkg::is_letter(c)) begin
                b_vld    = 1'b0;
                mode_d   = ModeIdent;
                prefix_d = sts_pkg::PrefixW'(c);
                wlen_d   = sts_pkg::WordLenW'(1);
              end
            end
          endcase
        end
      end
    end
  end

  // Pack toward slot 0 and mark the final result of the item
  always_comb begin
    push_o.vld0      = a_vld | b_vld;
    push_o.vld1      = a_vld & b_vld;
    push_o.res0      = a_vld ? a_res : b_res;
    push_o.res0.last = ~(a_vld & b_vld);
    push_o.res1      = b_res;
    push_o.res1.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeIdle;
      start_q  <= '0;
      pos_q    <= '0;
      line_q   <= sts_pkg::LineW'(1);
      prefix_q <= '0;
      wlen_q   <= '0;
    end else begin
      mode_q   <= mode_d;
      start_q  <= start_d;
      pos_q    <= pos_d;
      line_q   <= line_d;
      prefix_q <= prefix_d;
      wlen_q   <= wlen_d;
    end
  end

endmodule

### rtl/sts_result_fifo.sv
module sts_result_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sts_pkg::push_t    push_i,
  output logic              room2_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sts_pkg::result_t  out_res_o
);

  sts_pkg::result_t                 entry_q [sts_pkg::ResultDepth];
  logic [sts_pkg::ResultPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [sts_pkg::ResultPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [sts_pkg::ResultCntW-1:0]   count_q, count_d;
  logic [sts_pkg::ResultPtrW-1:0]   wr_ptr_next;
  logic                             pop;

  assign out_valid_o = (count_q != '0);
  assign out_res_o   = entry_q[rd_ptr_q];
  assign pop         = out_valid_o & out_ready_i;
  // Room for a full item's worth of results
  assign room2_o     = (count_q <= sts_pkg::ResultCntW'(sts_pkg::ResultDepth - 2));
  assign wr_ptr_next = wr_ptr_q + 1'b1;

  always_comb begin
    wr_ptr_d = wr_ptr_q + sts_pkg::ResultPtrW'(push_i.vld0)
                        + sts_pkg::ResultPtrW'(push_i.vld1);
    rd_ptr_d = rd_ptr_q + sts_pkg::ResultPtrW'(pop);
    count_d  = count_q + sts_pkg::ResultCntW'(push_i.vld0)
                       + sts_pkg::ResultCntW'(push_i.vld1)
                       - sts_pkg::ResultCntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.vld0) begin
      entry_q[wr_ptr_q] <= push_i.res0;
    end
    if (push_i.vld1) begin
      entry_q[wr_ptr_next] <= push_i.res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

### rtl/script_token_scanner_core.sv
// Channel  | Signals                                   | Direction
// ---------+-------------------------------------------+----------
// in       | in_valid_i, in_ready_o, cmd_i,            | input
//          | source_byte_i                             |
// out      | out_valid_o, out_ready_i, token_kind_o,   | output
//          | start_offset_o, text_length_o,            |
//          | line_number_o, unterminated_o,            |
//          | last_result_o                             |
//
// One item is accepted per cycle while the input is not stalled; it is held in
// an item register, scanned as it leaves that register, and its results are
// written into a 4-entry result queue behind one output port, which sets the
// sustained rate: items giving at most one result run at one per cycle, items
// giving two are limited by the single output port. Input stalls while the queue lacks room for two.
// Reset (rst_ni low) returns the scanner to the start of a new source.
module script_token_scanner_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       cmd_i,
  input  logic [sts_pkg::ByteW-1:0]  source_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [sts_pkg::KindW-1:0]  token_kind_o,
  output logic [sts_pkg::FieldW-1:0] start_offset_o,
  output logic [sts_pkg::FieldW-1:0] text_length_o,
  output logic [sts_pkg::LineW-1:0]  line_number_o,
  output logic                       unterminated_o,
  output logic                       last_result_o
);

  logic                       item_valid_q, item_valid_d;
  logic                       item_cmd_q;
  logic [sts_pkg::ByteW-1:0]  item_byte_q;
  logic                       room2;
  logic                       advance;
  logic                       load;
  sts_pkg::push_t             push;
  sts_pkg::result_t           out_res;

  assign advance    = item_valid_q & room2;
  assign in_ready_o = ~item_valid_q | room2;
  assign load       = in_valid_i & in_ready_o;

  always_comb begin
    item_valid_d = item_valid_q;
    if (load) begin
      item_valid_d = 1'b1;
    end else if (advance) begin
      item_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
    end
  end

  // Hold the item until the scanner takes it
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_cmd_q  <= cmd_i;
      item_byte_q <= source_byte_i;
    end
  end

  sts_scan u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (advance),
    .cmd_i         (item_cmd_q),
    .source_byte_i (item_byte_q),
    .push_o        (push)
  );

  sts_result_fifo u_result_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room2_o     (room2),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res)
  );

  assign token_kind_o   = out_res.kind;
  assign start_offset_o = out_res.start;
  assign text_length_o  = out_res.length;
  assign line_number_o  = out_res.line;
  assign unterminated_o = out_res.unterm;
  assign last_result_o  = out_res.last;

endmodule
